/* sv/segment_circle_intersect_assert.svh */
// Assertion macros shared by the segment and circle hit test modules.
`ifndef SEGMENT_CIRCLE_INTERSECT_ASSERT_SVH
`define SEGMENT_CIRCLE_INTERSECT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check that cond holds in the same cycle whenever trig holds.
`define SCI_ASSERT_SAME(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("segment_circle_intersect: same-cycle check failed");
// Check that cond holds in the cycle after trig holds.
`define SCI_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("segment_circle_intersect: next-cycle check failed");
`else
`define SCI_ASSERT_SAME(label, trig, cond)
`define SCI_ASSERT_NEXT(label, trig, cond)
`endif
`endif

/* sv/sci_pkg.sv */
// Shared constants, types and helpers for the segment and circle hit test.
package sci_pkg;

  localparam int COORD_BITS = 16;
  localparam int CW = (COORD_BITS < 16) ? COORD_BITS : 16;
  localparam int TOLERANCE = 1;
  localparam logic [7:0] TOL = 8'(TOLERANCE);

  // Wide fixed point numerators and square root geometry
  localparam int WW = 70;
  localparam int RAD_BITS = 63;
  localparam int ROOT_BITS = 48;
  localparam int REM_BITS = 52;

  // Configuration register indexes
  localparam logic [1:0] REG_CENTER_X = 2'd0;
  localparam logic [1:0] REG_CENTER_Y = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;

  typedef logic signed [16:0] rel_t;
  typedef logic signed [35:0] bound_t;
  typedef logic signed [WW-1:0] wide_t;

  // Everything the root and box stages need besides the square root itself
  typedef struct packed {
    logic        in_circle;
    logic        ok;
    wide_t       cu;
    wide_t       cv;
    logic [32:0] len;
    bound_t      ulo;
    bound_t      uhi;
    bound_t      vlo;
    bound_t      vhi;
    logic [15:0] adu;
    rel_t        sdv;
  } root_side_t;

  // Sign-extend a coordinate from its active width
  function automatic rel_t sext_coord(input logic [15:0] v);
    logic signed [CW-1:0] t;
    t = v[CW-1:0];
    return rel_t'(t);
  endfunction

endpackage

/* sv/sci_front.sv */
// Front pipeline: relative coordinates, products, discriminant and root classification.
`include "segment_circle_intersect_assert.svh"
module sci_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          in_fire,
  input  logic [15:0]                   start_x,
  input  logic [15:0]                   start_y,
  input  logic [15:0]                   end_x,
  input  logic [15:0]                   end_y,
  input  logic [15:0]                   center_x,
  input  logic [15:0]                   center_y,
  input  logic [14:0]                   radius,
  output logic                          out_valid,
  output sci_pkg::root_side_t           side,
  output logic [sci_pkg::RAD_BITS-1:0]  rad
);

  // stage 1
  logic v1;
  sci_pkg::rel_t ax, ay, bx, by;
  // stage 2
  logic v2;
  logic [31:0] sq_ax, sq_ay, sq_bx, sq_by;
  logic [29:0] r2_2;
  sci_pkg::rel_t au2, av2, bu2, bv2, du2r, dv2r;
  // stage 3
  logic v3, inside3;
  logic [31:0] dusq3, dvsq3;
  logic signed [33:0] pa3, pb3;
  sci_pkg::bound_t ulo3, uhi3, vlo3, vhi3;
  sci_pkg::rel_t du3, dv3;
  logic [29:0] r2_3;
  // stage 4
  logic v4, inside4, zero4;
  logic [32:0] len4;
  logic signed [33:0] c4;
  logic [21:0] tq4;
  logic [22:0] tc4;
  sci_pkg::bound_t ulo4, uhi4, vlo4, vhi4;
  sci_pkg::rel_t du4, dv4;
  logic [29:0] r2_4;
  // stage 5
  logic v5, inside5, zero5;
  logic [46:0] rl0_5;
  logic [45:0] rl1_5;
  logic [33:0] cc0_5;
  logic signed [34:0] cc1_5, mv0_5, mu0_5;
  logic signed [33:0] cc2_5, mv1_5, mu1_5;
  logic [32:0] len5;
  logic [21:0] tq5;
  logic [22:0] tc5;
  sci_pkg::bound_t ulo5, uhi5, vlo5, vhi5;
  logic [15:0] adu5;
  sci_pkg::rel_t sdv5;
  // stage 6
  logic v6, inside6, zero6;
  sci_pkg::wide_t rl6, cc6, mv6, mu6;
  logic [32:0] len6;
  logic [21:0] tq6;
  logic [22:0] tc6;
  sci_pkg::bound_t ulo6, uhi6, vlo6, vhi6;
  logic [15:0] adu6;
  sci_pkg::rel_t sdv6;
  // stage 7
  logic v7, inside7, zero7;
  sci_pkg::wide_t e7, cu7, cv7;
  logic [32:0] len7;
  logic [21:0] tq7;
  logic [22:0] tc7;
  sci_pkg::bound_t ulo7, uhi7, vlo7, vhi7;
  logic [15:0] adu7;
  sci_pkg::rel_t sdv7;
  // stage 8
  logic v8;

  // combinational next values
  sci_pkg::rel_t cx, cy, ax_next, ay_next, bx_next, by_next;
  sci_pkg::rel_t dx, dy;
  logic [16:0] adx, ady;
  logic ylong;
  logic signed [33:0] sq_ax_p, sq_ay_p, sq_bx_p, sq_by_p, dusq_p, dvsq_p;
  logic [29:0] r2_next;
  logic [32:0] sum_a, sum_b;
  sci_pkg::rel_t umin, umax, vmin, vmax;
  logic [39:0] tol;
  logic signed [17:0] cl;
  logic signed [16:0] ch;
  logic [16:0] adu_w;
  sci_pkg::wide_t ae;
  logic two, one;

  localparam logic [39:0] TOLWIDE = 40'(sci_pkg::TOL);

  // Stage 1: coordinates relative to the center
  always_comb begin
    cx = sci_pkg::sext_coord(center_x);
    cy = sci_pkg::sext_coord(center_y);
    ax_next = sci_pkg::sext_coord(start_x) - cx;
    ay_next = sci_pkg::sext_coord(start_y) - cy;
    bx_next = sci_pkg::sext_coord(end_x) - cx;
    by_next = sci_pkg::sext_coord(end_y) - cy;
  end

  // Stage 2: endpoint squares, axis choice
  always_comb begin
    dx = bx - ax;
    dy = by - ay;
    adx = dx[16] ? -dx : dx;
    ady = dy[16] ? -dy : dy;
    ylong = ady > adx;
    sq_ax_p = ax * ax;
    sq_ay_p = ay * ay;
    sq_bx_p = bx * bx;
    sq_by_p = by * by;
    r2_next = radius * radius;
  end

  // Stage 3: inside test, span products, widened box
  always_comb begin
    sum_a = {1'b0, sq_ax} + {1'b0, sq_ay};
    sum_b = {1'b0, sq_bx} + {1'b0, sq_by};
    dusq_p = du2r * du2r;
    dvsq_p = dv2r * dv2r;
    umin = (au2 < bu2) ? au2 : bu2;
    umax = (au2 < bu2) ? bu2 : au2;
    vmin = (av2 < bv2) ? av2 : bv2;
    vmax = (av2 < bv2) ? bv2 : av2;
  end

  // Stage 4 / 5 helpers
  always_comb begin
    tol = dusq3 * TOLWIDE;
    cl = $signed({1'b0, c4[16:0]});
    ch = c4[33:17];
    adu_w = du4[16] ? -du4 : du4;
  end

  // Stage 8: classify the discriminant against the tolerance
  always_comb begin
    ae = e7[sci_pkg::WW-1] ? -e7 : e7;
    two = e7 > sci_pkg::wide_t'(tq7);
    one = ae < sci_pkg::wide_t'(tc7);
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
    end else if (adv) begin
      v1 <= in_fire;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
      v8 <= v7;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (adv) begin
      ax <= ax_next;
      ay <= ay_next;
      bx <= bx_next;
      by <= by_next;

      sq_ax <= sq_ax_p[31:0];
      sq_ay <= sq_ay_p[31:0];
      sq_bx <= sq_bx_p[31:0];
      sq_by <= sq_by_p[31:0];
      r2_2 <= r2_next;
      au2 <= ylong ? ay : ax;
      av2 <= ylong ? ax : ay;
      bu2 <= ylong ? by : bx;
      bv2 <= ylong ? bx : by;
      du2r <= ylong ? dy : dx;
      dv2r <= ylong ? dx : dy;

      inside3 <= (sum_a < {3'b0, r2_2}) || (sum_b < {3'b0, r2_2});
      dusq3 <= dusq_p[31:0];
      dvsq3 <= dvsq_p[31:0];
      pa3 <= av2 * du2r;
      pb3 <= dv2r * au2;
      ulo3 <= (sci_pkg::bound_t'(umin) <<< 16) - sci_pkg::bound_t'(sci_pkg::TOL);
      uhi3 <= (sci_pkg::bound_t'(umax) <<< 16) + sci_pkg::bound_t'(sci_pkg::TOL);
      vlo3 <= (sci_pkg::bound_t'(vmin) <<< 16) - sci_pkg::bound_t'(sci_pkg::TOL);
      vhi3 <= (sci_pkg::bound_t'(vmax) <<< 16) + sci_pkg::bound_t'(sci_pkg::TOL);
      du3 <= du2r;
      dv3 <= dv2r;
      r2_3 <= r2_2;

      inside4 <= inside3;
      zero4 <= (du3 == '0);
      len4 <= {1'b0, dusq3} + {1'b0, dvsq3};
      c4 <= pa3 - pb3;
      tq4 <= tol[39:18];
      tc4 <= {1'b0, tol[39:18]} + {22'b0, |tol[17:0]};
      ulo4 <= ulo3;
      uhi4 <= uhi3;
      vlo4 <= vlo3;
      vhi4 <= vhi3;
      du4 <= du3;
      dv4 <= dv3;
      r2_4 <= r2_3;

      inside5 <= inside4;
      zero5 <= zero4;
      rl0_5 <= r2_4 * len4[16:0];
      rl1_5 <= r2_4 * len4[32:17];
      cc0_5 <= c4[16:0] * c4[16:0];
      cc1_5 <= ch * cl;
      cc2_5 <= ch * ch;
      mv0_5 <= dv4 * cl;
      mv1_5 <= dv4 * ch;
      mu0_5 <= du4 * cl;
      mu1_5 <= du4 * ch;
      len5 <= len4;
      tq5 <= tq4;
      tc5 <= tc4;
      ulo5 <= ulo4;
      uhi5 <= uhi4;
      vlo5 <= vlo4;
      vhi5 <= vhi4;
      adu5 <= adu_w[15:0];
      sdv5 <= du4[16] ? -dv4 : dv4;

      inside6 <= inside5;
      zero6 <= zero5;
      rl6 <= (sci_pkg::wide_t'(rl1_5) <<< 17) + sci_pkg::wide_t'(rl0_5);
      cc6 <= (sci_pkg::wide_t'(cc2_5) <<< 34) + (sci_pkg::wide_t'(cc1_5) <<< 18)
             + sci_pkg::wide_t'(cc0_5);
      mv6 <= (sci_pkg::wide_t'(mv1_5) <<< 17) + sci_pkg::wide_t'(mv0_5);
      mu6 <= (sci_pkg::wide_t'(mu1_5) <<< 17) + sci_pkg::wide_t'(mu0_5);
      len6 <= len5;
      tq6 <= tq5;
      tc6 <= tc5;
      ulo6 <= ulo5;
      uhi6 <= uhi5;
      vlo6 <= vlo5;
      vhi6 <= vhi5;
      adu6 <= adu5;
      sdv6 <= sdv5;

      inside7 <= inside6;
      zero7 <= zero6;
      e7 <= rl6 - cc6;
      cu7 <= -(mv6 <<< 16);
      cv7 <= mu6 <<< 16;
      len7 <= len6;
      tq7 <= tq6;
      tc7 <= tc6;
      ulo7 <= ulo6;
      uhi7 <= uhi6;
      vlo7 <= vlo6;
      vhi7 <= vhi6;
      adu7 <= adu6;
      sdv7 <= sdv6;

      side.in_circle <= inside7;
      side.ok <= !zero7 && (two || one);
      side.cu <= cu7;
      side.cv <= cv7;
      side.len <= len7;
      side.ulo <= ulo7;
      side.uhi <= uhi7;
      side.vlo <= vlo7;
      side.vhi <= vhi7;
      side.adu <= adu7;
      side.sdv <= sdv7;
      rad <= two ? e7[sci_pkg::RAD_BITS-1:0] : '0;
    end
  end

  assign out_valid = v8;

  // A nonzero radicand only comes from a two-root item
  `SCI_ASSERT_SAME(a_front_rad_ok, v8 && (rad != '0), side.ok)

endmodule

/* sv/sci_sqrt.sv */
// Pipelined restoring square root, one result bit per stage, with sideband.
`include "segment_circle_intersect_assert.svh"
module sci_sqrt (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            adv,
  input  logic                            in_valid,
  input  sci_pkg::root_side_t             in_side,
  input  logic [sci_pkg::RAD_BITS-1:0]    rad,
  output logic                            out_valid,
  output sci_pkg::root_side_t             out_side,
  output logic [sci_pkg::ROOT_BITS-1:0]   root
);

  localparam int N = sci_pkg::ROOT_BITS;
  localparam int XB = 2 * sci_pkg::ROOT_BITS;
  localparam int RB = sci_pkg::REM_BITS;
  localparam int LAST = sci_pkg::ROOT_BITS - 1;

  logic vq [N];
  logic [RB-1:0] rem_q [N];
  logic [N-1:0] root_q [N];
  logic [XB-1:0] x_q [N];
  sci_pkg::root_side_t side_q [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic v_in;
    logic [RB-1:0] rem_in, rem_sh, trial;
    logic [N-1:0] root_in;
    logic [XB-1:0] x_in;
    sci_pkg::root_side_t side_in;
    logic ge;

    // Select stage input
    if (k == 0) begin : g_first
      assign v_in = in_valid;
      assign rem_in = '0;
      assign root_in = '0;
      assign x_in = {1'b0, rad, 32'b0};
      assign side_in = in_side;
    end else begin : g_rest
      assign v_in = vq[k-1];
      assign rem_in = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign x_in = x_q[k-1];
      assign side_in = side_q[k-1];
    end

    // Bring down two radicand bits and try the next root bit
    always_comb begin
      rem_sh = {rem_in[RB-3:0], x_in[XB-1 -: 2]};
      trial = {{(RB-N-2){1'b0}}, root_in, 2'b01};
      ge = rem_sh >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vq[k] <= 1'b0;
      end else if (adv) begin
        vq[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_q[k] <= ge ? (rem_sh - trial) : rem_sh;
        root_q[k] <= {root_in[N-2:0], ge};
        x_q[k] <= x_in << 2;
        side_q[k] <= side_in;
      end
    end
  end

  assign out_valid = vq[LAST];
  assign out_side = side_q[LAST];
  assign root = root_q[LAST];

  // Restoring invariant: remainder never exceeds twice the root plus one
  `SCI_ASSERT_SAME(a_sqrt_rem, vq[LAST], (rem_q[LAST] >> 1) <= RB'(root_q[LAST]))
  // A stalled final stage keeps its item
  `SCI_ASSERT_NEXT(a_sqrt_hold, !adv && vq[LAST], vq[LAST])

endmodule

/* sv/sci_box.sv */
// Root coordinates and widened bounding box test.
module sci_box (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           adv,
  input  logic                           in_valid,
  input  sci_pkg::root_side_t            side,
  input  logic [sci_pkg::ROOT_BITS-1:0]  root,
  output logic                           out_valid,
  output logic                           hit_next
);

  // stage 1
  logic v1, inside1, ok1;
  sci_pkg::wide_t cu1, cv1;
  logic [39:0] pu0, pu1;
  logic signed [41:0] pv0, pv1;
  logic signed [53:0] ulo_l, uhi_l, vlo_l, vhi_l;
  logic signed [52:0] ulo_h, uhi_h, vlo_h, vhi_h;
  // stage 2
  logic v2, inside2, ok2;
  sci_pkg::wide_t cu2, cv2, pu2, pv2, ulo2, uhi2, vlo2, vhi2;
  // stage 3
  logic v3, inside3, ok3;
  sci_pkg::wide_t nup, num, nvp, nvm, ulo3, uhi3, vlo3, vhi3;

  logic signed [17:0] ll;
  logic signed [16:0] lh;
  logic signed [24:0] s0, s1;

  function automatic logic in_box(input sci_pkg::wide_t nu, input sci_pkg::wide_t nv,
                                  input sci_pkg::wide_t ul, input sci_pkg::wide_t uh,
                                  input sci_pkg::wide_t vl, input sci_pkg::wide_t vh);
    return (ul <= nu) && (nu <= uh) && (vl <= nv) && (nv <= vh);
  endfunction

  // Split length and root into multiplier-sized halves
  always_comb begin
    ll = $signed({1'b0, side.len[16:0]});
    lh = $signed({1'b0, side.len[32:17]});
    s0 = $signed({1'b0, root[23:0]});
    s1 = $signed({1'b0, root[47:24]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // partial products
      inside1 <= side.in_circle;
      ok1 <= side.ok;
      cu1 <= side.cu;
      cv1 <= side.cv;
      pu0 <= side.adu * root[23:0];
      pu1 <= side.adu * root[47:24];
      pv0 <= side.sdv * s0;
      pv1 <= side.sdv * s1;
      ulo_l <= side.ulo * ll;
      uhi_l <= side.uhi * ll;
      vlo_l <= side.vlo * ll;
      vhi_l <= side.vhi * ll;
      ulo_h <= side.ulo * lh;
      uhi_h <= side.uhi * lh;
      vlo_h <= side.vlo * lh;
      vhi_h <= side.vhi * lh;

      // sum partial products
      inside2 <= inside1;
      ok2 <= ok1;
      cu2 <= cu1;
      cv2 <= cv1;
      pu2 <= (sci_pkg::wide_t'(pu1) <<< 24) + sci_pkg::wide_t'(pu0);
      pv2 <= (sci_pkg::wide_t'(pv1) <<< 24) + sci_pkg::wide_t'(pv0);
      ulo2 <= (sci_pkg::wide_t'(ulo_h) <<< 17) + sci_pkg::wide_t'(ulo_l);
      uhi2 <= (sci_pkg::wide_t'(uhi_h) <<< 17) + sci_pkg::wide_t'(uhi_l);
      vlo2 <= (sci_pkg::wide_t'(vlo_h) <<< 17) + sci_pkg::wide_t'(vlo_l);
      vhi2 <= (sci_pkg::wide_t'(vhi_h) <<< 17) + sci_pkg::wide_t'(vhi_l);

      // both roots
      inside3 <= inside2;
      ok3 <= ok2;
      nup <= cu2 + pu2;
      num <= cu2 - pu2;
      nvp <= cv2 + pv2;
      nvm <= cv2 - pv2;
      ulo3 <= ulo2;
      uhi3 <= uhi2;
      vlo3 <= vlo2;
      vhi3 <= vhi2;
    end
  end

  // An endpoint inside the circle hits; else compare both roots against the widened box
  always_comb begin
    hit_next = inside3 || (ok3 &&
               (in_box(nup, nvp, ulo3, uhi3, vlo3, vhi3) ||
                in_box(num, nvm, ulo3, uhi3, vlo3, vhi3)));
  end

  assign out_valid = v3;

endmodule

/* sv/segment_circle_intersect.sv */
// Path from input acceptance to out_valid: front, square root, box and output stages.
// Throughput: one item per cycle unless held; the 48-stage root pipeline sets the depth.
// The pipeline holds only when the output register is full, untaken, and the last
// box stage holds an item; bubbles keep moving otherwise.
// Reset: synchronous; clears valid bits and the three config registers, no clearing pass.
`include "segment_circle_intersect_assert.svh"
module segment_circle_intersect (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] start_x,
  input  logic signed [15:0] start_y,
  input  logic signed [15:0] end_x,
  input  logic signed [15:0] end_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               hit
);

  logic [15:0] center_x, center_y;
  logic [14:0] radius;
  logic adv, in_fire;
  logic front_valid, sqrt_valid, box_valid, box_hit;
  sci_pkg::root_side_t front_side, sqrt_side;
  logic [sci_pkg::RAD_BITS-1:0] rad;
  logic [sci_pkg::ROOT_BITS-1:0] root;

  // Hold the pipeline only when the last box stage has nowhere to go
  assign adv = !(out_valid && !out_ready && box_valid);
  assign in_ready = adv;
  assign in_fire = in_valid && adv;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
      radius <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        sci_pkg::REG_CENTER_X: center_x <= cfg_data;
        sci_pkg::REG_CENTER_Y: center_y <= cfg_data;
        sci_pkg::REG_RADIUS:   radius <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  sci_front u_front (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_fire  (in_fire),
    .start_x  (start_x),
    .start_y  (start_y),
    .end_x    (end_x),
    .end_y    (end_y),
    .center_x (center_x),
    .center_y (center_y),
    .radius   (radius),
    .out_valid(front_valid),
    .side     (front_side),
    .rad      (rad)
  );

  sci_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (front_valid),
    .in_side  (front_side),
    .rad      (rad),
    .out_valid(sqrt_valid),
    .out_side (sqrt_side),
    .root     (root)
  );

  sci_box u_box (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (sqrt_valid),
    .side     (sqrt_side),
    .root     (root),
    .out_valid(box_valid),
    .hit_next (box_hit)
  );

  // Output register: load when the last stage moves, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && box_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && box_valid) begin
      hit <= box_hit;
    end
  end

  // A blocked output with a waiting result must stop intake
  `SCI_ASSERT_SAME(a_top_stall, out_valid && !out_ready && box_valid, !in_ready)

endmodule

/* tb/tb_segment_circle_intersect.sv */
// Testbench for the segment against circle hit test with a bit-exact predictor.
module tb_segment_circle_intersect;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [127:0] wide_num_t;

  localparam logic [1:0] REG_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 70;

  logic clk;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic signed [15:0] start_x;
  logic signed [15:0] start_y;
  logic signed [15:0] end_x;
  logic signed [15:0] end_y;
  logic out_valid;
  logic out_ready;
  logic hit;

  // Shadow copy of the circle registers
  logic signed [15:0] circ_cx;
  logic signed [15:0] circ_cy;
  logic [14:0] circ_r;

  bit expected_hits[$];
  int failures;
  int cycles;
  int out_stall_left;
  bit no_gaps;

  segment_circle_intersect i_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
    .out_valid(out_valid), .out_ready(out_ready), .hit(hit)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("segment_circle_intersect regression: fail");
      $finish;
    end
  end

  // Stall the result side: mostly ready, short stalls, a few long ones
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b1;
      out_stall_left <= 0;
    end else if (out_stall_left > 0) begin
      out_ready <= 1'b0;
      out_stall_left <= out_stall_left - 1;
    end else if (no_gaps || $urandom_range(0, 99) < 75) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
      out_stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(0, 3);
    end
  end

  // Compare each accepted result with the oldest expected hit flag
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_hits.size() == 0) begin
        $error("hit: unexpected result, actual %0d", hit);
        failures++;
      end else begin
        bit want;
        want = expected_hits.pop_front();
        if (hit !== want) begin
          $error("hit mismatch: expected %0d actual %0d", want, hit);
          failures++;
        end
      end
    end
  end

  function automatic wide_num_t isqrt(input wide_num_t x);
    wide_num_t s;
    wide_num_t t;
    s = 0;
    for (int b = 50; b >= 0; b--) begin
      t = s | (wide_num_t'(1) <<< b);
      if (t * t <= x) s = t;
    end
    return s;
  endfunction

  function automatic bit root_in_box(input wide_num_t nu, input wide_num_t nv,
                                     input wide_num_t len, input wide_num_t ulo,
                                     input wide_num_t uhi, input wide_num_t vlo,
                                     input wide_num_t vhi);
    return (ulo * len <= nu) && (nu <= uhi * len) && (vlo * len <= nv) &&
           (nv <= vhi * len);
  endfunction

  // Predict the hit flag for one segment under the current circle
  function automatic bit segment_hits_circle(input logic signed [15:0] sx,
                                             input logic signed [15:0] sy,
                                             input logic signed [15:0] ex,
                                             input logic signed [15:0] ey);
    wide_num_t ax, ay, bx, by, dx, dy, r2, au, av, du, dv, len, c, tol;
    wide_num_t f, e, s, cu, cv, pu, pv, sdv, ulo, uhi, vlo, vhi, af, adu;
    bit ylong;
    ax = wide_num_t'(sx) - wide_num_t'(circ_cx);
    ay = wide_num_t'(sy) - wide_num_t'(circ_cy);
    bx = wide_num_t'(ex) - wide_num_t'(circ_cx);
    by = wide_num_t'(ey) - wide_num_t'(circ_cy);
    r2 = wide_num_t'({1'b0, circ_r}) * wide_num_t'({1'b0, circ_r});
    if (ax * ax + ay * ay < r2 || bx * bx + by * by < r2) return 1'b1;
    dx = bx - ax;
    dy = by - ay;
    ylong = ((dy < 0) ? -dy : dy) > ((dx < 0) ? -dx : dx);
    au = ylong ? ay : ax;
    av = ylong ? ax : ay;
    du = ylong ? dy : dx;
    dv = ylong ? dx : dy;
    // A zero-length segment outside the circle never hits
    if (du == 0) return 1'b0;
    len = du * du + dv * dv;
    c = av * du - dv * au;
    tol = sci_pkg::TOLERANCE * du * du;
    f = (r2 * len <<< 18) - (c * c <<< 18);
    ulo = ((du < 0) ? au + du : au) * 65536 - sci_pkg::TOLERANCE;
    uhi = ((du < 0) ? au : au + du) * 65536 + sci_pkg::TOLERANCE;
    vlo = ((dv < 0) ? av + dv : av) * 65536 - sci_pkg::TOLERANCE;
    vhi = ((dv < 0) ? av : av + dv) * 65536 + sci_pkg::TOLERANCE;
    cu = -(dv * c * 65536);
    cv = du * c * 65536;
    if (tol < f) begin
      e = r2 * len - c * c;
      s = isqrt(e <<< 32);
      adu = (du < 0) ? -du : du;
      sdv = (du < 0) ? -dv : dv;
      pu = adu * s;
      pv = sdv * s;
      return root_in_box(cu + pu, cv + pv, len, ulo, uhi, vlo, vhi) ||
             root_in_box(cu - pu, cv - pv, len, ulo, uhi, vlo, vhi);
    end
    // Near-zero discriminant: one root; exactly at tolerance: none
    af = (f < 0) ? -f : f;
    return (af < tol) && root_in_box(cu, cv, len, ulo, uhi, vlo, vhi);
  endfunction

  function automatic logic signed [15:0] clip_coord(input int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return 16'(v);
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Send one segment and queue its predicted hit flag on acceptance
  task automatic send_segment(input int sx, input int sy, input int ex, input int ey);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    start_x <= clip_coord(sx);
    start_y <= clip_coord(sy);
    end_x <= clip_coord(ex);
    end_y <= clip_coord(ey);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_hits.push_back(segment_hits_circle(clip_coord(sx), clip_coord(sy),
                                                clip_coord(ex), clip_coord(ey)));
  endtask

  // Hold off input until every result is back and the pipeline is empty
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write one register, then leave the channel idle
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      sci_pkg::REG_CENTER_X: circ_cx = data;
      sci_pkg::REG_CENTER_Y: circ_cy = data;
      sci_pkg::REG_RADIUS: circ_r = data[14:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_circle(input int cx, input int cy, input int r);
    drain();
    write_reg(sci_pkg::REG_CENTER_X, 16'(cx));
    write_reg(sci_pkg::REG_CENTER_Y, 16'(cy));
    write_reg(sci_pkg::REG_RADIUS, 16'(r));
  endtask

  // Reset circle is a point at the origin: only nonzero-length segments through it hit
  task automatic test_reset_circle();
    send_segment(-10, 0, 10, 0);
    send_segment(-10, 1, 10, 1);
    send_segment(0, -5, 0, 7);
    send_segment(0, 0, 0, 0);
  endtask

  task automatic test_directed();
    set_circle(0, 0, 1000);
    // Drop a write to the unused index; circle must stay as is
    write_reg(REG_NONE, 16'h7fff);
    send_segment(10, 10, 5000, 5000);
    send_segment(5000, 5000, -20, 30);
    send_segment(-2000, 1000, 2000, 1000);
    send_segment(1000, 3000, 1000, -3000);
    send_segment(1000, 0, 3000, 0);
    send_segment(-3000, 0, 3000, 1);
    send_segment(3000, -3000, -3000, 3000);
    send_segment(2000, 2000, 2000, 2000);
    send_segment(5, 5, 5, 5);
    send_segment(-32768, -32768, 32767, 32767);
    send_segment(32767, -32768, -32768, 32767);
    send_segment(-32768, 32767, -32768, -32768);
    send_segment(1500, 0, 3000, 0);
    send_segment(0, -3000, 0, -1001);
    send_segment(-32768, 1001, 32767, 999);
    // Discriminant exactly at tolerance
    set_circle(0, 0, 1);
    send_segment(0, 1, 512, 2);
    send_segment(512, 2, 0, 1);
  endtask

  task automatic send_random_segment();
    int r, span, sel;
    r = circ_r;
    span = 2 * r + 40;
    sel = $urandom_range(0, 99);
    if (sel < 60) begin
      send_segment(int'(circ_cx) + $urandom_range(0, 2 * span) - span,
                   int'(circ_cy) + $urandom_range(0, 2 * span) - span,
                   int'(circ_cx) + $urandom_range(0, 2 * span) - span,
                   int'(circ_cy) + $urandom_range(0, 2 * span) - span);
    end else if (sel < 75) begin
      // Tangent-ish horizontal or vertical lines
      int off;
      off = r + $urandom_range(0, 2) - 1;
      if ($urandom_range(0, 1))
        send_segment(circ_cx - span, circ_cy + off, circ_cx + span, circ_cy + off);
      else
        send_segment(circ_cx - off, circ_cy + span, circ_cx - off, circ_cy - span);
    end else if (sel < 82) begin
      int px, py;
      px = int'(circ_cx) + $urandom_range(0, 2 * span) - span;
      py = int'(circ_cy) + $urandom_range(0, 2 * span) - span;
      send_segment(px, py, px, py);
    end else begin
      send_segment($signed(16'($urandom)), $signed(16'($urandom)),
                   $signed(16'($urandom)), $signed(16'($urandom)));
    end
  endtask

  task automatic test_random();
    int cxs[6] = '{0, -32768, 32767, 0, 100, 0};
    int cys[6] = '{0, -32768, 32767, 0, -200, 0};
    int rs[6] = '{1000, 32767, 0, 32767, 5, 0};
    for (int p = 0; p < 7; p++) begin
      if (p < 6) set_circle(cxs[p], cys[p], rs[p]);
      else set_circle($signed(16'($urandom)), $signed(16'($urandom)),
                      $urandom_range(0, 3000));
      no_gaps = (p == 3);
      for (int i = 0; i < 125; i++) send_random_segment();
    end
    no_gaps = 1'b0;
  endtask

  // Pause the sender until all results are in, then resume
  task automatic test_pause();
    for (int i = 0; i < 20; i++) send_random_segment();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_hits.size() != 0) @(posedge clk);
    for (int i = 0; i < 20; i++) send_random_segment();
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = sci_pkg::REG_CENTER_X;
    cfg_data = 16'd0;
    in_valid = 1'b0;
    start_x = 16'sd0;
    start_y = 16'sd0;
    end_x = 16'sd0;
    end_y = 16'sd0;
    circ_cx = 16'sd0;
    circ_cy = 16'sd0;
    circ_r = 15'd0;
    failures = 0;
    cycles = 0;
    no_gaps = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_circle();
    test_directed();
    test_random();
    test_pause();
    drain();
    if (failures == 0) begin
      $display("segment_circle_intersect regression: pass");
    end else begin
      $display("segment_circle_intersect regression: fail");
    end
    $finish;
  end

endmodule
